// ----- sv/ismin_pkg.sv -----
// Shared constants, item types and control structs for the range-minimum sequence block.
`timescale 1ns / 1ps

package ismin_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 9;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                    operation;
        logic [POS_W-1:0]        insert_position;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        range_start;
        logic [POS_W-1:0]        range_end;
    } req_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] minimum;
        logic                    range_empty;
        logic                    insert_dropped;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t              mode;
        logic [CMP_W-1:0]        pos;
        logic [CMP_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic             go;
        logic [CMP_W-1:0] lo;
        logic [CMP_W-1:0] hi;
    } scan_cmd_t;

    typedef struct packed {
        logic                    active;
        logic                    last;
        logic signed [VAL_W-1:0] minimum;
    } scan_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

endpackage

// ----- sv/ismin_cell.sv -----
// One storage cell of the sequence ring: hold, shift up on insert, rotate down on scan.
`timescale 1ns / 1ps

module ismin_cell (
    input  logic                             clk,
    input  logic [ismin_pkg::IDX_W-1:0]      idx,
    input  ismin_pkg::cell_cmd_t             cmd,
    input  logic signed [ismin_pkg::VAL_W-1:0] left,
    input  logic signed [ismin_pkg::VAL_W-1:0] right,
    output logic signed [ismin_pkg::VAL_W-1:0] value
);
    import ismin_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic [CMP_W-1:0]        idx_ext;

    assign idx_ext = CMP_W'(idx);

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.mode)
            CELL_INSERT:
            begin
                if (idx_ext == cmd.pos)
                begin
                    value_next = cmd.value;
                end
                else if (idx_ext > cmd.pos && idx_ext <= cmd.count)
                begin
                    value_next = left;
                end
            end
            CELL_ROTATE: value_next = right;
            CELL_HOLD:   value_next = value_reg;
            default:     value_next = value_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- sv/ismin_scan.sv -----
// Running-minimum unit that watches the head cell while the ring rotates.
`timescale 1ns / 1ps

module ismin_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ismin_pkg::scan_cmd_t               cmd,
    input  logic signed [ismin_pkg::VAL_W-1:0] head,
    output ismin_pkg::scan_stat_t              stat
);
    import ismin_pkg::*;

    logic                    active_reg, active_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [CMP_W-1:0]        lo_reg, lo_next;
    logic [CMP_W-1:0]        hi_reg, hi_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic                    in_range;
    logic                    last;

    assign in_range = (CMP_W'(step_reg) >= lo_reg) && (CMP_W'(step_reg) < hi_reg);
    assign last     = active_reg && (step_reg == IDX_W'(CAPACITY - 1));

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        acc_next    = acc_reg;
        if (cmd.go)
        begin
            active_next = 1'b1;
            step_next   = '0;
            lo_next     = cmd.lo;
            hi_next     = cmd.hi;
            acc_next    = VALUE_MAX;
        end
        else if (active_reg)
        begin
            if (in_range && head < acc_reg)
            begin
                acc_next = head;
            end
            step_next = step_reg + 1'b1;
            if (last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
    end

    assign stat.active  = active_reg;
    assign stat.last    = last;
    assign stat.minimum = acc_reg;

endmodule

// ----- sv/insertable_sequence_range_min_core.sv -----
// Top level: sequence ring of cells, insert/query sequencer and result register.
// Insert: once accepted, result in the output register the next cycle.
// Query: the ring makes a full turn past the head-cell comparator, then the result is
//   reported once the output register is free; the rotation restores the order.
// One item is worked on at a time; inserts sustain one item per cycle while rsp_ready is high.
// Reset clears the entry count and the control state; cell contents stay undefined.
`timescale 1ns / 1ps

module insertable_sequence_range_min_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ismin_pkg::req_item_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ismin_pkg::rsp_item_t  rsp
);
    import ismin_pkg::*;

    // Sequencer state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              empty_reg, empty_next;

    // Result register: lets a new query be taken while the last item waits
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;

    logic              accept;
    logic              full;
    logic              slot_free;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  start_ext;
    logic [CMP_W-1:0]  end_ext;
    logic [CMP_W-1:0]  end_clamped;

    cell_cmd_t         cell_cmd;
    scan_cmd_t         scan_cmd;
    scan_stat_t        scan_stat;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];

    assign full        = (cnt_reg == CNT_W'(CAPACITY));
    assign slot_free   = !rsp_valid_reg || rsp_ready;
    assign cnt_ext     = CMP_W'(cnt_reg);
    assign pos_ext     = CMP_W'(req.insert_position);
    assign start_ext   = CMP_W'(req.range_start);
    assign end_ext     = CMP_W'(req.range_end);
    // End of the query range never reaches past the stored entries
    assign end_clamped = (end_ext > cnt_ext) ? cnt_ext : end_ext;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        empty_next     = empty_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        accept         = 1'b0;
        cell_cmd.mode  = CELL_HOLD;
        // Broadcast to every cell; a position past the end turns into an append
        cell_cmd.pos   = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
        cell_cmd.count = cnt_ext;
        cell_cmd.value = req.item_value;
        scan_cmd.go    = 1'b0;
        scan_cmd.lo    = start_ext;
        scan_cmd.hi    = end_clamped;

        unique case (state_reg)
            ST_IDLE:
            begin
                // A query's result comes much later, so it needs no free slot now
                req_ready = (req.operation == OP_QUERY) || slot_free;
                accept    = req_valid && req_ready;
                if (accept)
                begin
                    if (req.operation == OP_INSERT)
                    begin
                        rsp_next.minimum        = '0;
                        rsp_next.range_empty    = 1'b0;
                        rsp_next.insert_dropped = full;
                        rsp_valid_next          = 1'b1;
                        if (!full)
                        begin
                            cell_cmd.mode = CELL_INSERT;
                            cnt_next      = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        scan_cmd.go = 1'b1;
                        empty_next  = (start_ext >= end_clamped);
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Full turn of the ring: every entry passes cell 0 once
                cell_cmd.mode = CELL_ROTATE;
                if (scan_stat.last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    rsp_next.minimum        = scan_stat.minimum;
                    rsp_next.range_empty    = empty_reg;
                    rsp_next.insert_dropped = 1'b0;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg <= empty_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Ring of cells: left neighbor feeds inserts, right neighbor feeds rotation
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ismin_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(i)),
            .cmd   (cell_cmd),
            .left  (cell_val[(i + CAPACITY - 1) % CAPACITY]),
            .right (cell_val[(i + 1) % CAPACITY]),
            .value (cell_val[i])
        );
    end

    // Minimum tracker on the head of the ring
    ismin_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scan_cmd),
        .head  (cell_val[0]),
        .stat  (scan_stat)
    );

    // No new item while a query turns the ring
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("item accepted during a query scan");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.operation == OP_INSERT && !full)
        |=> (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)))
        else $error("entry count did not advance on insert");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_scan_ends_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.last |=> (state_reg == ST_REPORT && !scan_stat.active))
        else $error("scan end not followed by report");

endmodule
